@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("concurrent assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("concurrent assertion failed");

`endif

@@ sv/lfia_pkg.sv @@
// ----------------------------------------------------------------------------
// lfia_pkg
// Codes, widths and controller/datapath link types of the allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

	// Field widths.
	localparam int IDX_W  = 10;
	localparam int ACT_W  = 2;
	localparam int KIND_W = 2;

	// Bitmap words are scanned 32 bits at a time.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	localparam int MAP_SIZE = 1024;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_MARK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLAIM = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd3;

	// Name kind codes; the unused code behaves as the unspaced form.
	localparam logic [KIND_W-1:0] KIND_BASE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPACED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNSPACED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted item
		logic rd;      // read one bitmap word
		logic adv;     // step the scan to the next word
		logic commit;  // write back and load the result register
	} lfia_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search;    // item needs a lowest-free scan of a bitmap
		logic found;     // current word holds a free entry
		logic last;      // current word is the last one of the map
		logic out_free;  // result register can take a new item
	} lfia_sts_t;

endpackage

@@ sv/lfia_req_if.sv @@
// ----------------------------------------------------------------------------
// lfia_req_if
// Request channel: one action on one name index per item.
// ----------------------------------------------------------------------------
interface lfia_req_if
	import lfia_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  index;

	modport source (output valid, action, kind, index, input ready);
	modport sink (input valid, action, kind, index, output ready);
endinterface

@@ sv/lfia_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lfia_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface lfia_rsp_if
	import lfia_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              was_free;
	logic [IDX_W-1:0]  granted_index;
	logic [KIND_W-1:0] granted_kind;
	logic              renamed;
	logic              full_res;

	modport source (output valid, was_free, granted_index, granted_kind, renamed, full_res,
		input ready);
	modport sink (input valid, was_free, granted_index, granted_kind, renamed, full_res,
		output ready);
endinterface

@@ sv/lfia_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfia_ctrl
// Sequencer: accepts an item, reads bitmap words one per cycle and commits.
// ----------------------------------------------------------------------------
module lfia_ctrl
	import lfia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  lfia_sts_t sts,
	output lfia_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Ready only between items; one item is in work at a time.
	assign req_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.search && !sts.found && !sts.last) begin
					// Keep scanning: the next word is read in this same cycle.
					cmd.adv = 1'b1;
					cmd.rd = 1'b1;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ sv/lfia_dp.sv @@
// ----------------------------------------------------------------------------
// lfia_dp
// Datapath: base flag, two word-organized bitmaps, scan logic and result.
// ----------------------------------------------------------------------------
module lfia_dp
	import lfia_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ACT_W-1:0]  action,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  index,
	input  lfia_cmd_t         cmd,
	output lfia_sts_t         sts,
	lfia_rsp_if.source        rsp
);

	localparam int LIMIT     = (DEPTH < MAP_SIZE) ? DEPTH : MAP_SIZE;
	localparam int NWORDS    = (LIMIT + WORD_W - 1) / WORD_W;
	localparam int WAW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int LAST_BITS = LIMIT - (NWORDS - 1) * WORD_W;

	// Item registers.
	logic [ACT_W-1:0]  act_q;
	logic [KIND_W-1:0] kind_q;
	logic [KIND_W-1:0] skind_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WAW-1:0]    word_q;
	logic              direct_q;
	logic              oob_q;
	logic              search_q;
	logic              first_q;
	logic              wf_q;

	// State.
	logic              base_taken_q;
	logic [WORD_W-1:0] mem_sp [NWORDS];
	logic [WORD_W-1:0] mem_un [NWORDS];
	logic              vld_sp_q [NWORDS];
	logic              vld_un_q [NWORDS];
	logic [WORD_W-1:0] rdata_q;
	logic              rvld_q;

	// Result register.
	logic              rsp_valid_q;
	logic              wf_out_q;
	logic [IDX_W-1:0]  gidx_q;
	logic [KIND_W-1:0] gkind_q;
	logic              renamed_q;
	logic              full_q;

	// Load-time decode.
	logic              is_claim_in;
	logic [KIND_W-1:0] kind_n;
	logic              redirect;
	logic              direct_in;
	logic [KIND_W-1:0] skind_in;
	logic [IDX_W-1:0]  start_in;
	logic              oob_in;

	// Scan-time signals.
	logic              is_claim;
	logic              map_sp;
	logic [WAW-1:0]    raddr;
	logic [WORD_W-1:0] word_eff;
	logic [WORD_W-1:0] occ;
	logic              found;
	logic [BIT_W-1:0]  pos;
	logic              last;
	logic              wf_now;
	logic [IDX_W-1:0]  gi;
	logic [BIT_W-1:0]  wbit;
	logic [WORD_W-1:0] wdata;
	logic              wr_en;
	logic              base_wr;

	// Decode of the incoming item; a claim or allocate of a taken base name redirects to the spaced map at 1.
	always_comb begin
		is_claim_in = (action == ACT_CLAIM) || (action == ACT_ALLOC);
		kind_n = (kind == KIND_SPARE) ? KIND_UNSPACED : kind;
		redirect = is_claim_in && (kind_n == KIND_BASE) && base_taken_q;
		direct_in = (kind_n == KIND_BASE) && !redirect;
		skind_in = redirect ? KIND_SPACED : kind_n;
		start_in = redirect ? IDX_W'(1) : index;
		oob_in = !direct_in && ({1'b0, start_in} >= (IDX_W + 1)'(LIMIT));
	end

	// Item capture and scan position.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			kind_q <= kind_n;
			skind_q <= skind_in;
			idx_q <= index;
			bit_q <= start_in[BIT_W-1:0];
			word_q <= WAW'(start_in >> BIT_W);
			direct_q <= direct_in;
			oob_q <= oob_in;
			search_q <= is_claim_in && !direct_in && !oob_in;
		end else if (cmd.adv) begin
			word_q <= WAW'(word_q + 1'b1);
			wf_q <= wf_now;
		end
	end

	// Marks the first word of a scan, where the requested entry sits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (cmd.load) begin
			first_q <= 1'b1;
		end else if (cmd.adv) begin
			first_q <= 1'b0;
		end
	end

	assign is_claim = (act_q == ACT_CLAIM) || (act_q == ACT_ALLOC);
	assign map_sp = (skind_q == KIND_SPACED);
	assign raddr = cmd.adv ? WAW'(word_q + 1'b1) : word_q;

	// Registered bitmap read; the word-valid bit stands in for a cleared row.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			if (map_sp) begin
				rdata_q <= mem_sp[raddr];
				rvld_q <= vld_sp_q[raddr];
			end else begin
				rdata_q <= mem_un[raddr];
				rvld_q <= vld_un_q[raddr];
			end
		end
	end

	// Find-first-free over one word, masking entries below the start and past the limit.
	always_comb begin
		word_eff = rvld_q ? rdata_q : '0;
		last = (word_q == WAW'(NWORDS - 1));
		occ = word_eff;
		for (int b = 0; b < WORD_W; b++) begin
			if (first_q && (BIT_W'(b) < bit_q)) begin
				occ[b] = 1'b1;
			end
			if (last && (b >= LAST_BITS)) begin
				occ[b] = 1'b1;
			end
		end
		found = !(&occ);
		pos = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!occ[b]) begin
				pos = BIT_W'(b);
			end
		end
	end

	// Free state of the requested entry, valid from the first word on.
	always_comb begin
		if (kind_q == KIND_BASE) begin
			wf_now = !base_taken_q;
		end else if (oob_q) begin
			wf_now = 1'b1;
		end else if (first_q) begin
			wf_now = !word_eff[bit_q];
		end else begin
			wf_now = wf_q;
		end
	end

	// Write-back of the word with the granted or marked entry set.
	always_comb begin
		gi = IDX_W'({word_q, pos});
		wbit = (act_q == ACT_MARK) ? bit_q : pos;
		wdata = word_eff | (WORD_W'(1) << wbit);
		wr_en = cmd.commit && !direct_q &&
			(((act_q == ACT_MARK) && !oob_q) || (search_q && found));
		base_wr = cmd.commit && direct_q && (act_q != ACT_QUERY);
	end

	always_ff @(posedge clk) begin
		if (wr_en && map_sp) begin
			mem_sp[word_q] <= wdata;
		end
		if (wr_en && !map_sp) begin
			mem_un[word_q] <= wdata;
		end
	end

	// Word-valid bits and the base flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_taken_q <= 1'b0;
			for (int w = 0; w < NWORDS; w++) begin
				vld_sp_q[w] <= 1'b0;
				vld_un_q[w] <= 1'b0;
			end
		end else begin
			if (base_wr) begin
				base_taken_q <= 1'b1;
			end
			if (wr_en && map_sp) begin
				vld_sp_q[word_q] <= 1'b1;
			end
			if (wr_en && !map_sp) begin
				vld_un_q[word_q] <= 1'b1;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			wf_out_q <= wf_now;
			renamed_q <= 1'b0;
			full_q <= 1'b0;
			gidx_q <= '0;
			gkind_q <= KIND_BASE;
			if (!is_claim) begin
				gidx_q <= (kind_q == KIND_BASE) ? '0 : idx_q;
				gkind_q <= kind_q;
				full_q <= (act_q == ACT_MARK) && oob_q;
			end else if (direct_q) begin
				gkind_q <= KIND_BASE;
			end else if (search_q && found) begin
				gidx_q <= gi;
				gkind_q <= skind_q;
				renamed_q <= (skind_q != kind_q) || (gi != idx_q);
			end else begin
				full_q <= 1'b1;
			end
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.was_free = wf_out_q;
	assign rsp.granted_index = gidx_q;
	assign rsp.granted_kind = gkind_q;
	assign rsp.renamed = renamed_q;
	assign rsp.full_res = full_q;

	// Status to the controller.
	assign sts.search = search_q;
	assign sts.found = found;
	assign sts.last = last;
	assign sts.out_free = !rsp_valid_q || rsp.ready;

endmodule

@@ sv/lowest_free_index_allocator.sv @@
// ----------------------------------------------------------------------------
// lowest_free_index_allocator
// Lowest-free index allocator for one name: base flag plus two bitmaps.
// ----------------------------------------------------------------------------
// One item is in work at a time. Mark, query and base-name items pass through
// the read and evaluate states once; the next item can be accepted once the
// result is committed. A claim or allocate on a bitmap scans 32-bit bitmap
// words, from the word of the requested index up to the word holding the
// lowest free entry (or the last word), so at most ceil(min(DEPTH,1024)/32)
// words per item: 32 at the default depth. The scan is bound by the single
// read port of the bitmap memory, one word per cycle. The result sits in an
// output register; the next item is accepted while it waits, but that item
// finishes only once the register is free. Bitmaps come out of reset clear
// at once through per-word valid bits; there is no clearing pass.
module lowest_free_index_allocator
	import lfia_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	lfia_req_if.sink   req,
	lfia_rsp_if.source rsp
);

	lfia_cmd_t cmd;
	lfia_sts_t sts;

	// Sequencer.
	lfia_ctrl u_lfia_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Bitmaps, scan and result register.
	lfia_dp #(
		.DEPTH (DEPTH)
	) u_lfia_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.action (req.action),
		.kind   (req.kind),
		.index  (req.index),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

@@ sv/lfia_checker.sv @@
// ----------------------------------------------------------------------------
// lfia_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfia_checker
	import lfia_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [KIND_W-1:0] rsp_granted_kind,
	input logic              rsp_renamed,
	input logic              rsp_full_res
);

	// A result stays offered until it is taken.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// Only one item is in work: acceptance closes the request side in the next cycle.
	`ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && req_ready, !req_ready)

	// The spare kind code is never reported back.
	`ASSERT_IMPL(a_kind_code, clk, arst_n, rsp_valid, rsp_granted_kind != KIND_SPARE)

	// A renamed grant always found room.
	`ASSERT_IMPL(a_renamed_not_full, clk, arst_n, rsp_valid && rsp_renamed, !rsp_full_res)

endmodule

bind lowest_free_index_allocator lfia_checker u_lfia_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted_kind (rsp.granted_kind),
	.rsp_renamed      (rsp.renamed),
	.rsp_full_res     (rsp.full_res)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lowest-free index allocator. A driver sends
// request items from a backlog and a monitor checks every result item against
// an in-bench prediction of the base flag and the two occupancy bitmaps. Both
// sides idle at random, the receiver holds off once for a long stretch, and
// the sender waits several times until every expected result has come.
// ----------------------------------------------------------------------------
module tb
	import lfia_pkg::*;
();

	localparam int ALLOC_DEPTH = 1024;
	localparam int LIMIT = (ALLOC_DEPTH < MAP_SIZE) ? ALLOC_DEPTH : MAP_SIZE;
	localparam int RANDOM_ITEMS = 725;
	localparam int HOLD_CYCLES = 250;
	localparam int TAIL_CYCLES = 64;

	// One request item, or a marker that makes the sender wait for all results.
	typedef struct packed {
		logic              drain;
		logic [ACT_W-1:0]  action;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  index;
	} alloc_req_t;

	// One result item as the block should report it.
	typedef struct packed {
		logic              was_free;
		logic [IDX_W-1:0]  granted_index;
		logic [KIND_W-1:0] granted_kind;
		logic              renamed;
		logic              full_res;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n;
	logic long_hold = 1'b0;

	lfia_req_if req_ch ();
	lfia_rsp_if rsp_ch ();

	lowest_free_index_allocator #(
		.DEPTH(ALLOC_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted occupancy of the allocator.
	bit base_held;
	bit spaced_used [MAP_SIZE];
	bit unspaced_used [MAP_SIZE];

	alloc_req_t request_backlog [$];
	grant_t pending_grants [$];

	int request_total = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int renames_seen = 0;
	int full_seen = 0;
	int redirects_seen = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_gap = 0;
	int recv_calm = 0;

	// Clock: 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Occupancy of one entry; entries at or above the limit are never held.
	function automatic bit entry_used(input logic [KIND_W-1:0] k, input int i);
		if (i >= LIMIT)
			return 1'b0;
		return (k == KIND_SPACED) ? spaced_used[i] : unspaced_used[i];
	endfunction

	function automatic void set_entry(input logic [KIND_W-1:0] k, input int i);
		if (k == KIND_SPACED)
			spaced_used[i] = 1'b1;
		else
			unspaced_used[i] = 1'b1;
	endfunction

	// Applies one request to the predicted state and returns its result.
	function automatic grant_t predict_grant(input logic [ACT_W-1:0] act,
		input logic [KIND_W-1:0] kind_in, input logic [IDX_W-1:0] idx);
		grant_t g;
		logic [KIND_W-1:0] knd;
		logic [KIND_W-1:0] scan_kind;
		int pos;
		bit hit;
		g = '0;
		knd = (kind_in == KIND_SPARE) ? KIND_UNSPACED : kind_in;
		if (knd == KIND_BASE)
			g.was_free = !base_held;
		else
			g.was_free = !entry_used(knd, int'(idx));
		if (act == ACT_MARK || act == ACT_QUERY) begin
			g.granted_index = (knd == KIND_BASE) ? '0 : idx;
			g.granted_kind = knd;
			if (act == ACT_MARK) begin
				if (knd == KIND_BASE)
					base_held = 1'b1;
				else if (int'(idx) < LIMIT)
					set_entry(knd, int'(idx));
				else
					g.full_res = 1'b1;
			end
		end else if (knd == KIND_BASE && !base_held) begin
			base_held = 1'b1;
		end else begin
			// Lowest free entry at or above the start; a taken base name
			// moves to the spaced form from index 1.
			scan_kind = knd;
			pos = int'(idx);
			if (knd == KIND_BASE) begin
				scan_kind = KIND_SPACED;
				pos = 1;
			end
			hit = 1'b0;
			while (pos < LIMIT && !hit) begin
				if (!entry_used(scan_kind, pos))
					hit = 1'b1;
				else
					pos++;
			end
			if (hit) begin
				set_entry(scan_kind, pos);
				g.granted_index = IDX_W'(pos);
				g.granted_kind = scan_kind;
				g.renamed = (scan_kind != knd) || (pos != int'(idx));
			end else begin
				g.full_res = 1'b1;
			end
		end
		return g;
	endfunction

	// Idle length after a handshake: mostly none or short, a few long, with
	// occasional runs of handshakes that have no idling at all.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_request(input logic [ACT_W-1:0] act, input logic [KIND_W-1:0] k,
		input int idx);
		alloc_req_t item;
		item.drain = 1'b0;
		item.action = act;
		item.kind = k;
		item.index = IDX_W'(idx);
		request_backlog.push_back(item);
		request_total++;
	endtask

	task automatic add_drain();
		alloc_req_t item;
		item = '0;
		item.drain = 1'b1;
		request_backlog.push_back(item);
	endtask

	// A random request: scans that grow the filled region from the bottom,
	// crowding near the bottom and the top, base-name items and some full noise.
	function automatic alloc_req_t random_request();
		alloc_req_t item;
		logic [KIND_W-1:0] map_kinds [3];
		int r;
		map_kinds = '{KIND_SPACED, KIND_UNSPACED, KIND_SPARE};
		item.drain = 1'b0;
		item.action = ACT_W'($urandom_range(0, (1 << ACT_W) - 1));
		item.kind = map_kinds[$urandom_range(0, 2)];
		r = $urandom_range(0, 99);
		if (r < 35) begin
			item.action = ($urandom_range(0, 1) == 0) ? ACT_ALLOC : ACT_CLAIM;
			if ($urandom_range(0, 9) < 7)
				item.kind = KIND_UNSPACED;
			item.index = IDX_W'($urandom_range(0, 15));
		end else if (r < 50) begin
			item.kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
			item.index = IDX_W'($urandom_range(0, 63));
		end else if (r < 65) begin
			item.index = IDX_W'($urandom_range(LIMIT - 32, LIMIT - 1));
		end else if (r < 75) begin
			item.kind = KIND_BASE;
			item.index = IDX_W'($urandom);
		end else begin
			item.kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
			item.index = IDX_W'($urandom);
		end
		return item;
	endfunction

	// Driver: offers backlog items, predicts each accepted one.
	always @(posedge clk) begin
		logic nxt_valid;
		grant_t g;
		alloc_req_t item;
		if (arst_n) begin
			nxt_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				g = predict_grant(req_ch.action, req_ch.kind, req_ch.index);
				pending_grants.push_back(g);
				items_sent++;
				if (g.renamed)
					renames_seen++;
				if (g.full_res)
					full_seen++;
				if (req_ch.kind == KIND_BASE && g.granted_kind == KIND_SPACED)
					redirects_seen++;
				nxt_valid = 1'b0;
				send_gap = idle_len(send_calm);
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_backlog.size() > 0) begin
					if (request_backlog[0].drain) begin
						if (pending_grants.size() == 0)
							void'(request_backlog.pop_front());
					end else begin
						item = request_backlog.pop_front();
						req_ch.action <= item.action;
						req_ch.kind <= item.kind;
						req_ch.index <= item.index;
						nxt_valid = 1'b1;
					end
				end
			end
			req_ch.valid <= nxt_valid;
		end
	end

	// Monitor: checks each result item against the oldest prediction.
	always @(posedge clk) begin
		grant_t exp_g;
		logic nxt_ready;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_grants.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result item: idx=%0d kind=%0d", rsp_ch.granted_index,
							rsp_ch.granted_kind);
				end else begin
					exp_g = pending_grants.pop_front();
					results_checked++;
					if (rsp_ch.was_free !== exp_g.was_free
						|| rsp_ch.granted_index !== exp_g.granted_index
						|| rsp_ch.granted_kind !== exp_g.granted_kind
						|| rsp_ch.renamed !== exp_g.renamed
						|| rsp_ch.full_res !== exp_g.full_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Result %0d mismatch: expected free=%0b idx=%0d kind=%0d ",
								"ren=%0b full=%0b, got free=%0b idx=%0d kind=%0d ren=%0b full=%0b"},
								results_checked, exp_g.was_free, exp_g.granted_index,
								exp_g.granted_kind, exp_g.renamed, exp_g.full_res,
								rsp_ch.was_free, rsp_ch.granted_index, rsp_ch.granted_kind,
								rsp_ch.renamed, rsp_ch.full_res);
					end
				end
				recv_gap = idle_len(recv_calm);
			end else if (!rsp_ch.valid && rsp_ch.ready && recv_gap == 0
				&& $urandom_range(0, 7) == 0) begin
				recv_gap = idle_len(recv_calm);
			end
			if (long_hold) begin
				nxt_ready = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			rsp_ch.ready <= nxt_ready;
		end
	end

	// One long receiver hold-off while the sender keeps offering items.
	initial begin
		while (items_sent < 300)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Stimulus, reset and end of run.
	initial begin
		alloc_req_t item;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_MARK;
		req_ch.kind = KIND_BASE;
		req_ch.index = '0;
		rsp_ch.ready = 1'b0;

		// Base name: free, claimed, then redirected to the spaced form.
		add_request(ACT_QUERY, KIND_BASE, 0);
		add_request(ACT_CLAIM, KIND_BASE, 1023);
		add_request(ACT_CLAIM, KIND_BASE, 0);
		add_request(ACT_ALLOC, KIND_BASE, 0);
		add_request(ACT_MARK, KIND_BASE, 0);
		add_request(ACT_QUERY, KIND_BASE, 512);
		// Spaced and unspaced claims that collide and get renamed.
		add_request(ACT_QUERY, KIND_SPACED, 0);
		add_request(ACT_MARK, KIND_SPACED, 0);
		add_request(ACT_CLAIM, KIND_SPACED, 0);
		add_request(ACT_CLAIM, KIND_UNSPACED, 0);
		add_request(ACT_ALLOC, KIND_UNSPACED, 0);
		// The spare kind code acts as the unspaced form.
		add_request(ACT_MARK, KIND_SPARE, 5);
		add_request(ACT_QUERY, KIND_SPARE, 5);
		add_request(ACT_CLAIM, KIND_SPARE, 5);
		// No room left at the top of the map.
		add_request(ACT_MARK, KIND_SPACED, 1023);
		add_request(ACT_CLAIM, KIND_SPACED, 1023);
		add_request(ACT_ALLOC, KIND_SPACED, 1023);
		add_request(ACT_QUERY, KIND_SPACED, 1023);
		add_request(ACT_CLAIM, KIND_UNSPACED, 1023);
		add_request(ACT_ALLOC, KIND_UNSPACED, 1022);
		add_request(ACT_ALLOC, KIND_UNSPACED, 1022);
		// Marking twice leaves one mark; a claim crosses a word boundary.
		add_request(ACT_MARK, KIND_UNSPACED, 1023);
		add_request(ACT_QUERY, KIND_UNSPACED, 682);
		add_request(ACT_CLAIM, KIND_SPACED, 31);
		add_request(ACT_CLAIM, KIND_SPACED, 31);
		add_drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 350 || n == 600)
				add_drain();
			item = random_request();
			add_request(item.action, item.kind, int'(item.index));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_sent < request_total)
			@(posedge clk);
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d request items: %0d renamed, %0d full, %0d base redirects.",
			items_sent, renames_seen, full_seen, redirects_seen);
		$display("Checked %0d result items, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && pending_grants.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding.", pending_grants.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
